FILE: rtl/core/tlst_pkg.sv
// ----------------------------------------------------------------------------
// tlst_pkg
// Shared types, codes and defaults of the transition latency statistics table.
// ----------------------------------------------------------------------------
`default_nettype none

package tlst_pkg;

    localparam int NUM_CPUS_DEF    = 8;
    localparam int TABLE_SLOTS_DEF = 64;

    localparam logic [31:0] SAT32_MAX = 32'hFFFF_FFFF;
    localparam logic [47:0] TOTAL_MAX = 48'hFFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_END   = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STS_DONE    = 2'd0,
        STS_IGNORED = 2'd1,
        STS_FULL    = 2'd2,
        STS_EMPTY   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PEND,
        ST_SEARCH,
        ST_UPDATE,
        ST_SLOT
    } state_t;

    typedef struct packed {
        logic [2:0]  cpu;
        logic [23:0] from_khz;
        logic [23:0] to_khz;
    } slot_key_t;

    typedef struct packed {
        logic        used;
        slot_key_t   key;
        logic [31:0] count;
        logic [47:0] total_us;
        logic [31:0] min_us;
        logic [31:0] max_us;
    } slot_entry_t;

    typedef struct packed {
        logic [23:0] from_khz;
        logic [23:0] to_khz;
        logic [47:0] time_us;
    } pend_entry_t;

endpackage

`default_nettype wire

FILE: rtl/core/transition_latency_stats_table.sv
// ----------------------------------------------------------------------------
// transition_latency_stats_table
// Per-key latency statistics (count, total, min, max) of frequency switches.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                  Payload
// -------   ---------  -------------------------  --------------------------------
// command   in         start & !busy              operation, cpu_id, from/to_freq_khz,
//                                                 timestamp_us, slot_index
// result    out        done (one-cycle strobe)    status, slot_valid, entry_*
// config    in         cfg_wr_en                  cfg_wr_data (profiling enable)
//
// Sequence: start events, ignored events and out-of-range slots answer in the cycle
// after the transaction is taken. Slot read/clear answers from ST_SLOT (table read).
// A switch end reads the pending start in ST_PEND, then ST_SEARCH compares one table
// slot per cycle with the shared key comparator, then ST_UPDATE writes the entry.
// A key hit in slot k ends the search early; a full table answers from ST_SEARCH
// after the last slot, without ST_UPDATE.
// Reset: the table used bits are swept clear, one slot per cycle, from slot 0 up to
// the last slot after reset; busy stays high meanwhile (config is taken).
// Stalls: the receiver cannot stall; a result is on the ports for one cycle.
//
`default_nettype none

module transition_latency_stats_table #(
    parameter int NUM_CPUS    = tlst_pkg::NUM_CPUS_DEF,
    parameter int TABLE_SLOTS = tlst_pkg::TABLE_SLOTS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_data,
    // command
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  operation,
    input  wire logic [2:0]  cpu_id,
    input  wire logic [23:0] from_freq_khz,
    input  wire logic [23:0] to_freq_khz,
    input  wire logic [47:0] timestamp_us,
    input  wire logic [5:0]  slot_index,
    // result
    output logic             done,
    output logic [1:0]       status,
    output logic             slot_valid,
    output logic [2:0]       entry_cpu,
    output logic [23:0]      entry_from_khz,
    output logic [23:0]      entry_to_khz,
    output logic [31:0]      entry_count,
    output logic [47:0]      entry_total_us,
    output logic [31:0]      entry_min_us,
    output logic [31:0]      entry_max_us
);

    localparam int CPU_W  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

    // ------------------------------------------------------------------
    // Storage
    // ------------------------------------------------------------------
    // Statistics table: one word per slot, used bit included, so the
    // after-reset sweep only has to write used = 0.
    tlst_pkg::slot_entry_t tbl_mem [TABLE_SLOTS];
    // Pending start per CPU; valid only behind pend_flag_reg.
    tlst_pkg::pend_entry_t pend_mem [NUM_CPUS];

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    tlst_pkg::state_t      state_reg, state_next;
    logic                  enable_reg;
    logic [NUM_CPUS-1:0]   pend_flag_reg, pend_flag_next;
    logic [SLOT_W-1:0]     clr_reg, clr_next;
    logic [SLOT_W-1:0]     chk_reg, chk_next;         // slot whose word is in tbl_rd_reg
    logic                  free_found_reg, free_found_next;
    logic [SLOT_W-1:0]     free_reg, free_next;
    logic [SLOT_W-1:0]     hit_reg, hit_next;         // slot being updated
    tlst_pkg::op_t         op_reg, op_next;
    logic [2:0]            cpu_reg, cpu_next;
    logic [47:0]           time_reg, time_next;
    logic [SLOT_W-1:0]     idx_reg, idx_next;
    logic [47:0]           dur_reg, dur_next;
    tlst_pkg::slot_key_t   key_reg, key_next;
    tlst_pkg::slot_entry_t ent_reg, ent_next;
    logic                  done_reg, done_next;
    tlst_pkg::status_t     status_reg, status_next;
    tlst_pkg::slot_entry_t res_reg, res_next;

    tlst_pkg::slot_entry_t tbl_rd_reg;
    tlst_pkg::pend_entry_t pend_rd_reg;

    // ------------------------------------------------------------------
    // Memory ports
    // ------------------------------------------------------------------
    logic                  tbl_we;
    logic [SLOT_W-1:0]     tbl_waddr;
    tlst_pkg::slot_entry_t tbl_wdata;
    logic [SLOT_W-1:0]     tbl_raddr;
    logic                  pend_we;
    tlst_pkg::pend_entry_t pend_wdata;

    logic [CPU_W-1:0]      in_cpu_idx;
    logic [CPU_W-1:0]      cpu_idx;
    logic                  in_cpu_ok;
    logic                  in_slot_ok;

    // update datapath
    logic [48:0]           total_sum;
    logic [31:0]           dur32;
    logic                  key_hit;
    tlst_pkg::slot_entry_t init_ent;
    tlst_pkg::slot_entry_t upd_ent;

    assign in_cpu_idx = CPU_W'(cpu_id);
    assign cpu_idx    = CPU_W'(cpu_reg);
    assign in_cpu_ok  = 32'(cpu_id) < NUM_CPUS;
    assign in_slot_ok = 32'(slot_index) < TABLE_SLOTS;

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[tbl_waddr] <= tbl_wdata;
        end
        tbl_rd_reg <= tbl_mem[tbl_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pend_we)
        begin
            pend_mem[in_cpu_idx] <= pend_wdata;
        end
        pend_rd_reg <= pend_mem[in_cpu_idx];
    end

    // ------------------------------------------------------------------
    // Update datapath: saturating total add and count increment, two 32-bit compares
    // ------------------------------------------------------------------
    assign dur32     = (|dur_reg[47:32]) ? tlst_pkg::SAT32_MAX : dur_reg[31:0];
    assign total_sum = {1'b0, ent_reg.total_us} + {1'b0, dur_reg};
    assign key_hit   = tbl_rd_reg.used && (tbl_rd_reg.key == key_reg);

    always_comb
    begin
        init_ent          = '0;
        init_ent.used     = 1'b1;
        init_ent.key      = key_reg;
        init_ent.min_us   = tlst_pkg::SAT32_MAX;

        upd_ent           = ent_reg;
        upd_ent.total_us  = total_sum[48] ? tlst_pkg::TOTAL_MAX : total_sum[47:0];
        if (ent_reg.count != tlst_pkg::SAT32_MAX)
        begin
            upd_ent.count = ent_reg.count + 32'd1;
        end
        if (dur32 > ent_reg.max_us)
        begin
            upd_ent.max_us = dur32;
        end
        if (dur32 < ent_reg.min_us)
        begin
            upd_ent.min_us = dur32;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        pend_flag_next  = pend_flag_reg;
        clr_next        = clr_reg;
        chk_next        = chk_reg;
        free_found_next = free_found_reg;
        free_next       = free_reg;
        hit_next        = hit_reg;
        op_next         = op_reg;
        cpu_next        = cpu_reg;
        time_next       = time_reg;
        idx_next        = idx_reg;
        dur_next        = dur_reg;
        key_next        = key_reg;
        ent_next        = ent_reg;
        done_next       = 1'b0;
        status_next     = tlst_pkg::STS_DONE;
        res_next        = '0;

        tbl_we          = 1'b0;
        tbl_waddr       = hit_reg;
        tbl_wdata       = upd_ent;
        tbl_raddr       = chk_reg + SLOT_W'(1);
        pend_we         = 1'b0;
        pend_wdata      = '{from_khz: from_freq_khz, to_khz: to_freq_khz,
                            time_us: timestamp_us};

        case (state_reg)
            tlst_pkg::ST_CLEAR:
            begin
                tbl_we         = 1'b1;
                tbl_waddr      = clr_reg;
                tbl_wdata      = '0;
                clr_next       = clr_reg + SLOT_W'(1);
                if (clr_reg == LAST_SLOT)
                begin
                    state_next = tlst_pkg::ST_IDLE;
                end
            end

            tlst_pkg::ST_IDLE:
            begin
                tbl_raddr = SLOT_W'(slot_index);
                if (start)
                begin
                    op_next   = tlst_pkg::op_t'(operation);
                    cpu_next  = cpu_id;
                    time_next = timestamp_us;
                    idx_next  = SLOT_W'(slot_index);
                    case (tlst_pkg::op_t'(operation))
                        tlst_pkg::OP_START,
                        tlst_pkg::OP_END:
                        begin
                            if (!enable_reg || !in_cpu_ok)
                            begin
                                done_next   = 1'b1;
                                status_next = tlst_pkg::STS_IGNORED;
                            end
                            else if (operation == tlst_pkg::OP_START)
                            begin
                                pend_we                    = 1'b1;
                                pend_flag_next[in_cpu_idx] = 1'b1;
                                done_next                  = 1'b1;
                            end
                            else if (!pend_flag_reg[in_cpu_idx])
                            begin
                                done_next   = 1'b1;
                                status_next = tlst_pkg::STS_IGNORED;
                            end
                            else
                            begin
                                state_next = tlst_pkg::ST_PEND;
                            end
                        end
                        tlst_pkg::OP_READ,
                        tlst_pkg::OP_CLEAR:
                        begin
                            if (!in_slot_ok)
                            begin
                                done_next   = 1'b1;
                                status_next = tlst_pkg::STS_EMPTY;
                            end
                            else
                            begin
                                state_next = tlst_pkg::ST_SLOT;
                            end
                        end
                        default:
                        begin
                            state_next = tlst_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            tlst_pkg::ST_PEND:
            begin
                // pending start is in pend_rd_reg; issue slot 0 read
                dur_next        = time_reg - pend_rd_reg.time_us;
                key_next        = '{cpu: cpu_reg, from_khz: pend_rd_reg.from_khz,
                                    to_khz: pend_rd_reg.to_khz};
                tbl_raddr       = '0;
                chk_next        = '0;
                free_found_next = 1'b0;
                state_next      = tlst_pkg::ST_SEARCH;
            end

            tlst_pkg::ST_SEARCH:
            begin
                if (!tbl_rd_reg.used && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_next       = chk_reg;
                end
                if (key_hit)
                begin
                    ent_next   = tbl_rd_reg;
                    hit_next   = chk_reg;
                    state_next = tlst_pkg::ST_UPDATE;
                end
                else if (chk_reg == LAST_SLOT)
                begin
                    if (free_found_reg || !tbl_rd_reg.used)
                    begin
                        ent_next   = init_ent;
                        hit_next   = free_found_reg ? free_reg : chk_reg;
                        state_next = tlst_pkg::ST_UPDATE;
                    end
                    else
                    begin
                        done_next   = 1'b1;
                        status_next = tlst_pkg::STS_FULL;
                        state_next  = tlst_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    chk_next = chk_reg + SLOT_W'(1);
                end
            end

            tlst_pkg::ST_UPDATE:
            begin
                tbl_we                  = 1'b1;
                pend_flag_next[cpu_idx] = 1'b0;
                done_next               = 1'b1;
                state_next              = tlst_pkg::ST_IDLE;
            end

            tlst_pkg::ST_SLOT:
            begin
                done_next  = 1'b1;
                state_next = tlst_pkg::ST_IDLE;
                if (!tbl_rd_reg.used)
                begin
                    status_next = tlst_pkg::STS_EMPTY;
                end
                else if (op_reg == tlst_pkg::OP_CLEAR)
                begin
                    tbl_we    = 1'b1;
                    tbl_waddr = idx_reg;
                    tbl_wdata = '0;
                end
                else
                begin
                    res_next = tbl_rd_reg;
                end
            end

            default:
            begin
                state_next = tlst_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tlst_pkg::ST_CLEAR;
            enable_reg     <= 1'b0;
            pend_flag_reg  <= '0;
            clr_reg        <= '0;
            free_found_reg <= 1'b0;
            done_reg       <= 1'b0;
            status_reg     <= tlst_pkg::STS_DONE;
            res_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_flag_reg  <= pend_flag_next;
            clr_reg        <= clr_next;
            free_found_reg <= free_found_next;
            done_reg       <= done_next;
            status_reg     <= status_next;
            res_reg        <= res_next;
            if (cfg_wr_en)
            begin
                enable_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        chk_reg  <= chk_next;
        free_reg <= free_next;
        hit_reg  <= hit_next;
        op_reg   <= op_next;
        cpu_reg  <= cpu_next;
        time_reg <= time_next;
        idx_reg  <= idx_next;
        dur_reg  <= dur_next;
        key_reg  <= key_next;
        ent_reg  <= ent_next;
    end

    // ------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------
    assign busy           = (state_reg != tlst_pkg::ST_IDLE);
    assign done           = done_reg;
    assign status         = status_reg;
    assign slot_valid     = res_reg.used;
    assign entry_cpu      = res_reg.key.cpu;
    assign entry_from_khz = res_reg.key.from_khz;
    assign entry_to_khz   = res_reg.key.to_khz;
    assign entry_count    = res_reg.count;
    assign entry_total_us = res_reg.total_us;
    assign entry_min_us   = res_reg.min_us;
    assign entry_max_us   = res_reg.max_us;

endmodule

`default_nettype wire

FILE: rtl/core/tlst_checker.sv
// ----------------------------------------------------------------------------
// tlst_checker
// Port-level checks of the latency statistics table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tlst_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic [1:0]  status,
    input wire logic        slot_valid,
    input wire logic [31:0] entry_count
);

    // a taken transaction either answers next cycle or keeps the block busy
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || done)
        else $error("accepted transaction neither answered nor busy");

    // results only appear once the sequencer is back to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // entry data only with a successful read
    a_valid_read: assert property (@(posedge clk) disable iff (!rst_n)
        slot_valid |-> done && status == tlst_pkg::STS_DONE)
        else $error("slot_valid outside a successful read");

    // an allocated entry always holds at least one completed switch
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        slot_valid |-> entry_count != 32'd0)
        else $error("occupied slot with zero count");

endmodule

bind transition_latency_stats_table tlst_checker u_tlst_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .status      (status),
    .slot_valid  (slot_valid),
    .entry_count (entry_count)
);

`default_nettype wire
